[design/aasw_pkg.sv]
// Shared constants for the ADC angle smoothing window block.
package aasw_pkg;

    // Field widths fixed by the register map
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int ALPHA_W         = 17;
    localparam int ANGLE_W         = 32;
    localparam int MARGIN_W        = 31;
    localparam int FRAC_BITS       = 16;
    localparam int CFG_DATA_W      = 32;
    localparam int CFG_IDX_W       = 3;

    // Accumulator width that holds the angle average sum
    localparam int ANG_ACC_W = ANGLE_W + FRAC_BITS + 2;

    // Unity weight in Q1.16
    localparam logic [ALPHA_W-1:0] ONE_Q16 = 17'h10000;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_WEIGHT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_LOW    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_HIGH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_LOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_HIGH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_MARGIN  = 3'd5;

    // Register reset values
    localparam int ALPHA_RST      = 6554;
    localparam int LEVEL_LOW_RST  = 0;
    localparam int LEVEL_HIGH_RST = 4095;
    localparam int ANGLE_LOW_RST  = 0;
    localparam int ANGLE_HIGH_RST = 23592960;
    localparam int MARGIN_RST     = 0;

endpackage

[design/aasw_divider.sv]
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
module aasw_divider #(
    parameter int DIVD_W = 44,
    parameter int DVSR_W = 12
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [DVSR_W-1:0] divisor,
    output logic              done,
    output logic [DIVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVD_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DIVD_W-1:0] quo_reg;
    logic [DVSR_W-1:0] rem_reg;
    logic [DVSR_W-1:0] dvsr_reg;

    logic [DVSR_W:0]   shifted;
    logic [DVSR_W+1:0] trial;

    // Trial subtract of the divisor from the shifted partial remainder
    always_comb begin
        shifted = {rem_reg, quo_reg[DIVD_W-1]};
        trial   = {1'b0, shifted} - {2'b00, dvsr_reg};
    end

    // Shift one dividend bit in and one quotient bit out per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            if (start) begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
                cnt_reg  <= '0;
                quo_reg  <= dividend;
                rem_reg  <= '0;
                dvsr_reg <= divisor;
            end else if (busy_reg) begin
                if (trial[DVSR_W+1]) begin
                    rem_reg <= shifted[DVSR_W-1:0];
                    quo_reg <= {quo_reg[DIVD_W-2:0], 1'b0};
                end else begin
                    rem_reg <= trial[DVSR_W-1:0];
                    quo_reg <= {quo_reg[DIVD_W-2:0], 1'b1};
                end
                cnt_reg  <= cnt_reg + 1'b1;
                done_reg <= (cnt_reg == CNT_W'(DIVD_W - 1));
                if (cnt_reg == CNT_W'(DIVD_W - 1)) begin
                    busy_reg <= 1'b0;
                end
            end else begin
                done_reg <= 1'b0;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[design/adc_angle_smoothing_window.sv]
// Top level: two-stage exponential smoothing with linear level-to-angle map.
//
// Each beat on the s_ channel carries one converter sample. The block averages
// it into the level average (weight alpha_weight, Q1.16, capped at one), maps
// the truncated level linearly from level_low..level_high onto
// angle_low..angle_high (Q16.16, saturated), averages that into the angle
// average with the same weight, and returns the level, the angle and the
// working-area flag as one beat on the m_ channel. Both averages start at zero
// after reset. One sample is in work at a time; a finished result waits in the
// output register while the next sample is taken. A sample passes through
// three shift-add multiplies that retire one bit of the multiplier per cycle and
// a restoring divider that retires one quotient bit per cycle. When level_low
// equals level_high the map multiply and the divide are skipped and only the
// two averaging multiplies run. Write the registers only while no sample is
// in work.
module adc_angle_smoothing_window
    import aasw_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration write port
    input  logic                         cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    // sample channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [SAMPLE_BITS-1:0]       s_raw_sample,
    // result channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [SAMPLE_BITS-1:0]       m_smoothed_level,
    output logic signed [ANGLE_W-1:0]    m_smoothed_angle,
    output logic                         m_in_working_area
);

    localparam int SB     = SAMPLE_BITS;
    localparam int MUL_W  = (SB > ALPHA_W) ? SB : ALPHA_W;
    localparam int CNT_W  = $clog2(MUL_W);
    localparam int DIVD_W = SB + ANGLE_W;
    localparam int ACC_W  = (DIVD_W + 1 > ANG_ACC_W) ? DIVD_W + 1 : ANG_ACC_W;
    localparam int SUM_W  = DIVD_W + 2;
    localparam int BND_W  = ANGLE_W + 2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_LVL,
        ST_LVL_DONE,
        ST_MUL_MAP,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_MAP_SUM,
        ST_ANG_SETUP,
        ST_MUL_ANG,
        ST_ANG_DONE,
        ST_FINISH
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [ALPHA_W-1:0]        alpha_reg;
    logic [SB-1:0]             level_low_reg;
    logic [SB-1:0]             level_high_reg;
    logic signed [ANGLE_W-1:0] angle_low_reg;
    logic signed [ANGLE_W-1:0] angle_high_reg;
    logic [MARGIN_W-1:0]       margin_reg;

    // averages
    logic [SB-1:0]             level_avg_reg;
    logic signed [ANGLE_W-1:0] angle_avg_reg;

    // serial datapath
    logic [CNT_W-1:0]          cnt_reg;
    logic [MUL_W-1:0]          mul_reg;
    logic signed [ACC_W-1:0]   mcand_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic                      neg_reg;
    logic signed [DIVD_W:0]    quot_reg;
    logic signed [ANGLE_W-1:0] mapped_reg;
    logic signed [BND_W-1:0]   lower_reg;
    logic signed [BND_W-1:0]   upper_reg;

    // output register
    logic                      m_valid_reg;
    logic [SB-1:0]             m_level_reg;
    logic signed [ANGLE_W-1:0] m_angle_reg;
    logic                      m_inside_reg;

    // combinational helpers
    logic [ALPHA_W-1:0]        alpha_eff;
    logic signed [SB:0]        lvl_diff;
    logic [SB-1:0]             level_new;
    logic signed [SB:0]        lrange;
    logic [SB-1:0]             lrange_mag;
    logic signed [SB:0]        ldelta;
    logic [SB-1:0]             ldelta_mag;
    logic signed [ANGLE_W:0]   adelta;
    logic [ANGLE_W-1:0]        adelta_mag;
    logic signed [ANGLE_W:0]   ang_diff;
    logic signed [SUM_W-1:0]   map_sum;
    logic                      map_fits;
    logic signed [ACC_W-1:0]   acc_round;
    logic signed [ANGLE_W-1:0] angle_new;
    logic signed [BND_W-1:0]   angle_ext;
    logic                      area_hit;
    logic                      mul_last;
    logic                      in_beat;
    logic                      out_free;
    logic                      out_load;
    logic                      div_start;
    logic                      div_done;
    logic [DIVD_W-1:0]         div_quo;

    // Cap the weight at one and form the signed differences
    always_comb begin
        alpha_eff  = alpha_reg[ALPHA_W-1] ? ONE_Q16 : alpha_reg;
        lvl_diff   = $signed({1'b0, s_raw_sample}) - $signed({1'b0, level_avg_reg});
        level_new  = acc_reg[SB+FRAC_BITS-1:FRAC_BITS];
        lrange     = $signed({1'b0, level_high_reg}) - $signed({1'b0, level_low_reg});
        lrange_mag = lrange[SB] ? SB'(-lrange) : lrange[SB-1:0];
        ldelta     = $signed({1'b0, level_new}) - $signed({1'b0, level_low_reg});
        ldelta_mag = ldelta[SB] ? SB'(-ldelta) : ldelta[SB-1:0];
        adelta     = $signed({angle_high_reg[ANGLE_W-1], angle_high_reg})
                   - $signed({angle_low_reg[ANGLE_W-1], angle_low_reg});
        adelta_mag = adelta[ANGLE_W] ? ANGLE_W'(-adelta) : adelta[ANGLE_W-1:0];
        ang_diff   = $signed({mapped_reg[ANGLE_W-1], mapped_reg})
                   - $signed({angle_avg_reg[ANGLE_W-1], angle_avg_reg});
    end

    // Add the offset to the quotient and saturate to 32 bits
    always_comb begin
        map_sum  = SUM_W'(angle_low_reg) + SUM_W'(quot_reg);
        map_fits = (&map_sum[SUM_W-1:ANGLE_W-1]) | ~(|map_sum[SUM_W-1:ANGLE_W-1]);
    end

    // Round the angle sum toward zero before dropping the fraction; test the average against the margin bounds
    always_comb begin
        acc_round = acc_reg + $signed({{(ACC_W-FRAC_BITS){1'b0}},
                                       {FRAC_BITS{acc_reg[ACC_W-1]}}});
        angle_new = acc_round[FRAC_BITS+ANGLE_W-1:FRAC_BITS];
        angle_ext = BND_W'(angle_avg_reg);
        area_hit  = (angle_ext > lower_reg) && (angle_ext < upper_reg);
    end

    assign mul_last  = (cnt_reg == CNT_W'(MUL_W - 1));
    assign in_beat   = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign out_load  = (state_reg == ST_FINISH) && out_free;
    assign div_start = (state_reg == ST_DIV_START);

    aasw_divider #(
        .DIVD_W (DIVD_W),
        .DVSR_W (SB)
    ) u_aasw_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (acc_reg[DIVD_W-1:0]),
        .divisor  (lrange_mag),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Hold state, configuration, averages and the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            m_valid_reg    <= 1'b0;
            alpha_reg      <= ALPHA_W'(ALPHA_RST);
            level_low_reg  <= SB'(LEVEL_LOW_RST);
            level_high_reg <= SB'(LEVEL_HIGH_RST);
            angle_low_reg  <= ANGLE_W'(ANGLE_LOW_RST);
            angle_high_reg <= ANGLE_W'(ANGLE_HIGH_RST);
            margin_reg     <= MARGIN_W'(MARGIN_RST);
            level_avg_reg  <= '0;
            angle_avg_reg  <= '0;
        end else begin
            // register writes; unknown indexes drop
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_ALPHA_WEIGHT: alpha_reg      <= cfg_data[ALPHA_W-1:0];
                    CFG_LEVEL_LOW:    level_low_reg  <= cfg_data[SB-1:0];
                    CFG_LEVEL_HIGH:   level_high_reg <= cfg_data[SB-1:0];
                    CFG_ANGLE_LOW:    angle_low_reg  <= $signed(cfg_data[ANGLE_W-1:0]);
                    CFG_ANGLE_HIGH:   angle_high_reg <= $signed(cfg_data[ANGLE_W-1:0]);
                    CFG_EDGE_MARGIN:  margin_reg     <= cfg_data[MARGIN_W-1:0];
                    default: ;
                endcase
            end

            // drop the result once taken, unless the next one loads now
            if (m_valid_reg && m_ready && !out_load) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (in_beat) begin
                        acc_reg   <= $signed({{(ACC_W-SB-FRAC_BITS){1'b0}},
                                              level_avg_reg, {FRAC_BITS{1'b0}}});
                        mcand_reg <= ACC_W'(lvl_diff);
                        mul_reg   <= MUL_W'(alpha_eff);
                        cnt_reg   <= '0;
                        state_reg <= ST_MUL_LVL;
                    end
                end
                ST_MUL_LVL, ST_MUL_MAP, ST_MUL_ANG: begin
                    // retire one multiplier bit
                    if (mul_reg[0]) begin
                        acc_reg <= acc_reg + mcand_reg;
                    end
                    mcand_reg <= mcand_reg <<< 1;
                    mul_reg   <= mul_reg >> 1;
                    if (mul_last) begin
                        cnt_reg <= '0;
                        unique case (state_reg)
                            ST_MUL_LVL: state_reg <= ST_LVL_DONE;
                            ST_MUL_MAP: state_reg <= ST_DIV_START;
                            default:    state_reg <= ST_ANG_DONE;
                        endcase
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_LVL_DONE: begin
                    level_avg_reg <= level_new;
                    if (lrange == '0) begin
                        mapped_reg <= angle_low_reg;
                        state_reg  <= ST_ANG_SETUP;
                    end else begin
                        acc_reg   <= '0;
                        mcand_reg <= ACC_W'(adelta_mag);
                        mul_reg   <= MUL_W'(ldelta_mag);
                        neg_reg   <= ldelta[SB] ^ adelta[ANGLE_W] ^ lrange[SB];
                        state_reg <= ST_MUL_MAP;
                    end
                end
                ST_DIV_START: begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT: begin
                    if (div_done) begin
                        quot_reg  <= neg_reg ? -$signed({1'b0, div_quo})
                                             : $signed({1'b0, div_quo});
                        state_reg <= ST_MAP_SUM;
                    end
                end
                ST_MAP_SUM: begin
                    if (map_fits) begin
                        mapped_reg <= map_sum[ANGLE_W-1:0];
                    end else begin
                        mapped_reg <= map_sum[SUM_W-1] ? {1'b1, {(ANGLE_W-1){1'b0}}}
                                                       : {1'b0, {(ANGLE_W-1){1'b1}}};
                    end
                    state_reg <= ST_ANG_SETUP;
                end
                ST_ANG_SETUP: begin
                    acc_reg   <= ACC_W'($signed({angle_avg_reg, {FRAC_BITS{1'b0}}}));
                    mcand_reg <= ACC_W'(ang_diff);
                    mul_reg   <= MUL_W'(alpha_eff);
                    cnt_reg   <= '0;
                    state_reg <= ST_MUL_ANG;
                end
                ST_ANG_DONE: begin
                    angle_avg_reg <= angle_new;
                    lower_reg     <= BND_W'(angle_low_reg)
                                   + $signed({{(BND_W-MARGIN_W){1'b0}}, margin_reg});
                    upper_reg     <= BND_W'(angle_high_reg)
                                   - $signed({{(BND_W-MARGIN_W){1'b0}}, margin_reg});
                    state_reg     <= ST_FINISH;
                end
                ST_FINISH: begin
                    // load the output once the previous beat has left
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_level_reg  <= level_avg_reg;
                        m_angle_reg  <= angle_avg_reg;
                        m_inside_reg <= area_hit;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready           = (state_reg == ST_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_smoothed_level  = m_level_reg;
    assign m_smoothed_angle  = m_angle_reg;
    assign m_in_working_area = m_inside_reg;

endmodule

[design/aasw_checker.sv]
// Port-level checks for the ADC angle smoothing window, bound to the top level.
module aasw_checker
    import aasw_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic [SAMPLE_BITS-1:0]    m_smoothed_level,
    input logic [ANGLE_W-1:0]        m_smoothed_angle,
    input logic                      m_in_working_area
);

    // A stalled result beat stays with its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_smoothed_level)
            && $stable(m_smoothed_angle) && $stable(m_in_working_area))
        else $error("result beat changed while stalled");

    // One sample in work at a time: ready drops after each accepted beat
    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("sample accepted while another is in work");

    // A new result appears only at the end of a sample's work
    a_out_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared without a sample in work");

    // Reset empties the output and leaves the block ready
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("reset did not clear the block");

endmodule

bind adc_angle_smoothing_window aasw_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_aasw_checker (.*);

[tb/sv/tb_adc_angle_smoothing_window.sv]
// Self-checking testbench for the ADC angle smoothing window block.
module tb_adc_angle_smoothing_window
    import aasw_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W      = SAMPLE_BITS_DEF;
    localparam int IDLE_PAUSE    = 8;
    localparam int DRAIN_CYCLES  = 150;
    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int RAND_PHASES   = 13;
    localparam int PHASE_ITEMS   = 125;
    localparam int PRINT_LIMIT   = 25;

    // Indexes outside the register map, written to check that they are ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct {
        logic [SAMPLE_W-1:0]       level;
        logic signed [ANGLE_W-1:0] angle;
        logic                      in_area;
    } angle_result_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_data = '0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic [SAMPLE_W-1:0]        s_raw_sample = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [SAMPLE_W-1:0]        m_smoothed_level;
    logic signed [ANGLE_W-1:0]  m_smoothed_angle;
    logic                       m_in_working_area;

    // Predictor copy of the registers and of both averages
    logic [ALPHA_W-1:0]         cfg_alpha = ALPHA_W'(ALPHA_RST);
    logic [SAMPLE_W-1:0]        cfg_lvl_lo = SAMPLE_W'(LEVEL_LOW_RST);
    logic [SAMPLE_W-1:0]        cfg_lvl_hi = SAMPLE_W'(LEVEL_HIGH_RST);
    logic signed [ANGLE_W-1:0]  cfg_ang_lo = ANGLE_W'(ANGLE_LOW_RST);
    logic signed [ANGLE_W-1:0]  cfg_ang_hi = ANGLE_W'(ANGLE_HIGH_RST);
    logic [MARGIN_W-1:0]        cfg_margin = MARGIN_W'(MARGIN_RST);
    logic [SAMPLE_W-1:0]        lvl_avg = '0;
    logic signed [ANGLE_W-1:0]  ang_avg = '0;

    angle_result_t  expected_results[$];
    logic           no_idle = 1'b0;
    int unsigned    cycle_count = 0;
    int             mismatch_count = 0;
    int             samples_sent = 0;
    int             results_checked = 0;
    int             windows_applied = 0;

    adc_angle_smoothing_window #(
        .SAMPLE_BITS(SAMPLE_W)
    ) u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_raw_sample      (s_raw_sample),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_smoothed_level  (m_smoothed_level),
        .m_smoothed_angle  (m_smoothed_angle),
        .m_in_working_area (m_in_working_area)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still due",
                     cycle_count, expected_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Advance both averages by one sample and return the expected beat
    function automatic angle_result_t smooth_and_map(input logic [SAMPLE_W-1:0] raw);
        longint unity, wt, inv_wt, lvl_sum, span, num, mapped, ang_sum, angle;
        longint lower, upper;
        angle_result_t r;
        unity = longint'(ONE_Q16);
        if (cfg_alpha > ONE_Q16) begin
            wt = unity;
        end else begin
            wt = longint'(cfg_alpha);
        end
        inv_wt = unity - wt;
        lvl_sum = wt * longint'(raw) + inv_wt * longint'(lvl_avg);
        r.level = SAMPLE_W'(lvl_sum >> FRAC_BITS);

        span = longint'(cfg_lvl_hi) - longint'(cfg_lvl_lo);
        if (span == 0) begin
            mapped = longint'(cfg_ang_lo);
        end else begin
            num = (longint'(r.level) - longint'(cfg_lvl_lo))
                * (longint'(cfg_ang_hi) - longint'(cfg_ang_lo));
            mapped = clamp32(longint'(cfg_ang_lo) + num / span);
        end

        ang_sum = wt * mapped + inv_wt * longint'(ang_avg);
        angle = clamp32(ang_sum / unity);
        r.angle = ANGLE_W'(angle);

        lower = longint'(cfg_ang_lo) + longint'(cfg_margin);
        upper = longint'(cfg_ang_hi) - longint'(cfg_margin);
        r.in_area = (angle > lower) && (angle < upper);

        lvl_avg = r.level;
        ang_avg = r.angle;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) begin
            $display("Mismatch on %s at result %0d: got %0d, expected %0d",
                     what, results_checked, got, want);
        end
    endtask

    function automatic int draw_gap();
        int pick;
        if (no_idle) return 0;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 120);
    endfunction

    // Drive one sample beat and record its expected result on acceptance
    task automatic push_sample(input logic [SAMPLE_W-1:0] raw);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_raw_sample <= raw;
        do @(posedge aclk); while (!s_ready);
        expected_results.push_back(smooth_and_map(raw));
        samples_sent++;
    endtask

    // Hold the sample channel until every result is back
    task automatic settle_idle();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (IDLE_PAUSE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            CFG_ALPHA_WEIGHT: cfg_alpha = data[ALPHA_W-1:0];
            CFG_LEVEL_LOW:    cfg_lvl_lo = data[SAMPLE_W-1:0];
            CFG_LEVEL_HIGH:   cfg_lvl_hi = data[SAMPLE_W-1:0];
            CFG_ANGLE_LOW:    cfg_ang_lo = data[ANGLE_W-1:0];
            CFG_ANGLE_HIGH:   cfg_ang_hi = data[ANGLE_W-1:0];
            CFG_EDGE_MARGIN:  cfg_margin = data[MARGIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_window(input logic [CFG_DATA_W-1:0] alpha_w, lo_w, hi_w,
                                  input logic [CFG_DATA_W-1:0] alo_w, ahi_w, margin_w);
        settle_idle();
        write_reg(CFG_ALPHA_WEIGHT, alpha_w);
        write_reg(CFG_LEVEL_LOW, lo_w);
        write_reg(CFG_LEVEL_HIGH, hi_w);
        write_reg(CFG_ANGLE_LOW, alo_w);
        write_reg(CFG_ANGLE_HIGH, ahi_w);
        write_reg(CFG_EDGE_MARGIN, margin_w);
        windows_applied++;
    endtask

    // Compare each result beat with the oldest prediction
    always @(posedge aclk) begin : result_check
        angle_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected beat level", longint'(m_smoothed_level), -1);
            end else begin
                want = expected_results.pop_front();
                if (m_smoothed_level !== want.level)
                    report_mismatch("smoothed_level", longint'(m_smoothed_level),
                                    longint'(want.level));
                if (m_smoothed_angle !== want.angle)
                    report_mismatch("smoothed_angle", longint'(m_smoothed_angle),
                                    longint'(want.angle));
                if (m_in_working_area !== want.in_area)
                    report_mismatch("in_working_area", longint'(m_in_working_area),
                                    longint'(want.in_area));
            end
            results_checked++;
        end
    end

    // Stall the result channel in random bursts
    initial begin : result_sink
        int run;
        int stall;
        forever begin
            run = $urandom_range(1, 12);
            m_ready <= 1'b1;
            repeat (run) @(posedge aclk);
            stall = draw_gap();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    // Defaults after reset: extreme and alternating samples
    task automatic test_reset_defaults();
        push_sample('0);
        push_sample('1);
        push_sample('1);
        push_sample(12'hAAA);
        push_sample(12'h555);
        push_sample('0);
    endtask

    // Writes to unmapped indexes must leave every register alone
    task automatic test_unknown_index();
        settle_idle();
        write_reg(CFG_SPARE_LO, '1);
        write_reg(CFG_SPARE_HI, '1);
        push_sample(12'd3000);
    endtask

    // Weight of one, of zero, and above one (taken as one)
    task automatic test_alpha_limits();
        settle_idle();
        write_reg(CFG_ALPHA_WEIGHT, 32'(ONE_Q16));
        push_sample('1);
        push_sample('0);
        settle_idle();
        write_reg(CFG_ALPHA_WEIGHT, '0);
        push_sample('1);
        settle_idle();
        write_reg(CFG_ALPHA_WEIGHT, 32'h0001_FFFF);
        push_sample(12'd2048);
        push_sample(12'd100);
    endtask

    // Equal, reversed and saturating level ranges
    task automatic test_level_bounds();
        program_window(32'(ONE_Q16), 32'd2000, 32'd2000, -(32'd5 << FRAC_BITS),
                       32'd90 << FRAC_BITS, 32'd0);
        push_sample(12'd3000);
        push_sample(12'd100);
        program_window(32'(ONE_Q16), 32'd4095, 32'd0, 32'd0,
                       32'd180 << FRAC_BITS, 32'd0);
        push_sample(12'd1000);
        push_sample(12'd3000);
        program_window(32'(ONE_Q16), 32'd2000, 32'd2001, 32'd0,
                       32'h7FFF_FFFF, 32'd0);
        push_sample('1);
        push_sample('0);
        program_window(32'(ONE_Q16), 32'd0, 32'd4095, 32'h8000_0000,
                       32'h7FFF_FFFF, 32'd0);
        push_sample('0);
        push_sample('1);
    endtask

    // Margin wider than the range, a normal margin, and the range ends
    task automatic test_margin_edges();
        program_window(32'(ONE_Q16), 32'd0, 32'd4095, 32'd0,
                       32'd90 << FRAC_BITS, 32'h7FFF_FFFF);
        push_sample(12'd2048);
        settle_idle();
        write_reg(CFG_EDGE_MARGIN, 32'd10 << FRAC_BITS);
        push_sample(12'd2048);
        push_sample('0);
        settle_idle();
        write_reg(CFG_EDGE_MARGIN, '0);
        push_sample('0);
    endtask

    // Random windows, each followed by noisy samples around moving targets
    task automatic test_random_windows();
        logic [ALPHA_W-1:0]         alpha;
        logic [SAMPLE_W-1:0]        lo, hi;
        logic signed [ANGLE_W-1:0]  ang_a, ang_b, ang_t;
        logic [MARGIN_W-1:0]        margin;
        logic [CFG_DATA_W-1:0]      alpha_w, lo_w, hi_w, margin_w;
        longint                     span;
        int                         target, v;
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            case ($urandom_range(0, 9))
                0:       alpha = ALPHA_W'($urandom_range(0, 131071));
                1:       alpha = ONE_Q16;
                2, 3:    alpha = ALPHA_W'($urandom_range(40000, 65536));
                default: alpha = ALPHA_W'($urandom_range(1500, 65536));
            endcase
            lo = SAMPLE_W'($urandom());
            hi = ($urandom_range(0, 6) == 0) ? lo : SAMPLE_W'($urandom());
            if ($urandom_range(0, 1) == 0) begin
                ang_a = $urandom();
                ang_b = $urandom();
            end else begin
                ang_a = -(32'($urandom_range(0, 180)) << FRAC_BITS);
                ang_b = 32'($urandom_range(0, 180)) << FRAC_BITS;
                if ($urandom_range(0, 4) == 0) begin
                    ang_t = ang_a;
                    ang_a = ang_b;
                    ang_b = ang_t;
                end
            end
            span = longint'(ang_b) - longint'(ang_a);
            if (span < 0) span = -span;
            case ($urandom_range(0, 3))
                0:       margin = '0;
                1:       margin = MARGIN_W'($urandom());
                default: margin = MARGIN_W'(span / $urandom_range(4, 40));
            endcase
            // Fill the unused upper bits of each word with noise
            alpha_w = $urandom();
            alpha_w[ALPHA_W-1:0] = alpha;
            lo_w = $urandom();
            lo_w[SAMPLE_W-1:0] = lo;
            hi_w = $urandom();
            hi_w[SAMPLE_W-1:0] = hi;
            margin_w = $urandom();
            margin_w[MARGIN_W-1:0] = margin;
            program_window(alpha_w, lo_w, hi_w, ang_a, ang_b, margin_w);

            target = $urandom_range(0, 4095);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                no_idle = (phase % 2 == 1) && (k < 30);
                if (k % 32 == 31) target = $urandom_range(0, 4095);
                case ($urandom_range(0, 9))
                    6, 7:    v = $urandom_range(0, 4095);
                    8:       v = ($urandom_range(0, 1) == 0) ? 0 : 4095;
                    9:       v = (int'(lo) + int'(hi)) / 2 + $urandom_range(0, 16) - 8;
                    default: v = target + $urandom_range(0, 64) - 32;
                endcase
                if (v < 0) v = 0;
                if (v > 4095) v = 4095;
                push_sample(SAMPLE_W'(v));
            end
            no_idle = 1'b0;
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_unknown_index();
        test_alpha_limits();
        test_level_bounds();
        test_margin_edges();
        test_random_windows();

        // Drain the pipeline
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d samples across %0d programmed windows, checked %0d results",
                 samples_sent, windows_applied, results_checked);
        $display("Mismatches: %0d, cycles used: %0d", mismatch_count, cycle_count);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
design/aasw_pkg.sv
design/aasw_divider.sv
design/adc_angle_smoothing_window.sv
design/aasw_checker.sv
tb/sv/tb_adc_angle_smoothing_window.sv
